// ----- rtl/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants shared by the 1-Wire bus master blocks.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int CntW  = 10;
  localparam int CfgDW = 10;
  localparam int CfgAW = 3;

  // command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // register indexes
  localparam logic [CfgAW-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [CfgAW-1:0] REG_RESET_REL   = 3'd1;
  localparam logic [CfgAW-1:0] REG_PRES_WAIT   = 3'd2;
  localparam logic [CfgAW-1:0] REG_PRES_LOW    = 3'd3;
  localparam logic [CfgAW-1:0] REG_SLOT_SHORT  = 3'd4;
  localparam logic [CfgAW-1:0] REG_SLOT_LONG   = 3'd5;
  localparam logic [CfgAW-1:0] REG_READ_SAMPLE = 3'd6;
  localparam logic [CfgAW-1:0] REG_READ_RECOV  = 3'd7;

  // sequencer phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RST_LOW  = 4'd1;
  localparam logic [3:0] PH_RST_REL  = 4'd2;
  localparam logic [3:0] PH_WAIT_LOW = 4'd3;
  localparam logic [3:0] PH_WAIT_HI  = 4'd4;
  localparam logic [3:0] PH_W_LOW    = 4'd5;
  localparam logic [3:0] PH_W_REL    = 4'd6;
  localparam logic [3:0] PH_R_LOW    = 4'd7;
  localparam logic [3:0] PH_R_SAMP   = 4'd8;
  localparam logic [3:0] PH_R_REC    = 4'd9;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] reset_release_ticks;
    logic [9:0] presence_wait_limit;
    logic [9:0] presence_low_limit;
    logic [7:0] slot_short_ticks;
    logic [7:0] slot_long_ticks;
    logic [7:0] read_sample_ticks;
    logic [7:0] read_recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      phase;
    logic [CntW-1:0] tick_count;
    logic [2:0]      bit_index;
    logic [7:0]      shift_byte;
    logic            presence_flag;
    logic [7:0]      last_read;
  } seq_state_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       device_present;
  } result_t;

endpackage

// ----- rtl/owbm_if.sv -----
// ----------------------------------------------------------------------------
// owbm_tick_if / owbm_result_if
// Valid/ready channels for bus ticks and per-tick results.
// ----------------------------------------------------------------------------
interface owbm_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] write_value;
  logic       line_level;

  modport source (output valid, output cmd, output write_value, output line_level,
                  input ready);
  modport sink (input valid, input cmd, input write_value, input line_level,
                output ready);
endinterface

interface owbm_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_value;
  logic       device_present;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_value, output device_present, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input read_value, input device_present, output ready);
endinterface

// ----- rtl/one_wire_bus_master_top.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// Tick-driven 1-Wire bus master: reset/presence, write byte, read byte.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        carries
//  tick      in    valid/ready      cmd, write_value, line_level
//  result    out   valid/ready      drive_low, busy_res, done_res,
//                                   read_value, device_present
//  cfg_*     in    write enable     8 timing registers, index 0..7
//
//  One tick transaction per cycle; its result is registered and appears in the next cycle.
//  The sequencer step and its single count compare set the cycle time.
//  Ticks are taken while the result register is empty or being drained.
//  Reset (rst, synchronous) returns the sequencer to idle and registers
//  to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top (
  input  logic                        clk,
  input  logic                        rst,
  owbm_tick_if.sink                   tick,
  owbm_result_if.source               result,
  input  logic                        cfg_we,
  input  logic [owbm_pkg::CfgAW-1:0]  cfg_index,
  input  logic [owbm_pkg::CfgDW-1:0]  cfg_data
);
  import owbm_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  result_t    res_next;
  result_t    res;
  logic       res_valid;
  logic       accept;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbm_step u_step (
    .cfg         (cfg),
    .cur         (state),
    .cmd         (tick.cmd),
    .write_value (tick.write_value),
    .line_level  (tick.line_level),
    .nxt         (state_next),
    .res         (res_next)
  );

  assign tick.ready = !res_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) state <= state_next;
      if (accept) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign result.valid          = res_valid;
  assign result.drive_low      = res.drive_low;
  assign result.busy_res       = res.busy_res;
  assign result.done_res       = res.done_res;
  assign result.read_value     = res.read_value;
  assign result.device_present = res.device_present;

endmodule

// ----- rtl/owbm_cfg.sv -----
// ----------------------------------------------------------------------------
// owbm_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [owbm_pkg::CfgAW-1:0]  cfg_index,
  input  logic [owbm_pkg::CfgDW-1:0]  cfg_data,
  output owbm_pkg::cfg_t              cfg
);
  import owbm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= 10'd750;
      cfg.reset_release_ticks <= 8'd15;
      cfg.presence_wait_limit <= 10'd200;
      cfg.presence_low_limit  <= 10'd240;
      cfg.slot_short_ticks    <= 8'd2;
      cfg.slot_long_ticks     <= 8'd60;
      cfg.read_sample_ticks   <= 8'd12;
      cfg.read_recovery_ticks <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:   cfg.reset_low_ticks     <= cfg_data;
        REG_RESET_REL:   cfg.reset_release_ticks <= cfg_data[7:0];
        REG_PRES_WAIT:   cfg.presence_wait_limit <= cfg_data;
        REG_PRES_LOW:    cfg.presence_low_limit  <= cfg_data;
        REG_SLOT_SHORT:  cfg.slot_short_ticks    <= cfg_data[7:0];
        REG_SLOT_LONG:   cfg.slot_long_ticks     <= cfg_data[7:0];
        REG_READ_SAMPLE: cfg.read_sample_ticks   <= cfg_data[7:0];
        REG_READ_RECOV:  cfg.read_recovery_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/owbm_step.sv -----
// ----------------------------------------------------------------------------
// owbm_step
// Next-state and result logic of the bus sequencer for one tick.
// ----------------------------------------------------------------------------
module owbm_step (
  input  owbm_pkg::cfg_t       cfg,
  input  owbm_pkg::seq_state_t cur,
  input  logic [1:0]           cmd,
  input  logic [7:0]           write_value,
  input  logic                 line_level,
  output owbm_pkg::seq_state_t nxt,
  output owbm_pkg::result_t    res
);
  import owbm_pkg::*;

  logic            start;
  logic [3:0]      ph;
  logic [CntW-1:0] tc;
  logic [2:0]      bi;
  logic [7:0]      sb;
  logic [CntW-1:0] tc_base;
  logic [CntW-1:0] tc_inc;
  logic [CntW-1:0] len;
  logic            over;
  logic            drive;
  logic            done;

  // command takes effect on the tick it arrives, if the sequencer is idle
  always_comb begin
    start = (cur.phase == PH_IDLE) && (cmd != CMD_NONE);
    ph    = cur.phase;
    tc    = cur.tick_count;
    bi    = cur.bit_index;
    sb    = cur.shift_byte;
    if (start) begin
      tc = '0;
      bi = '0;
      unique case (cmd)
        CMD_RESET: ph = PH_RST_LOW;
        CMD_WRITE: begin
          ph = PH_W_LOW;
          sb = write_value;
        end
        default: begin
          ph = PH_R_LOW;
          sb = '0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (ph)
      PH_RST_LOW:  len = cfg.reset_low_ticks;
      PH_RST_REL:  len = {2'b00, cfg.reset_release_ticks};
      PH_WAIT_LOW: len = line_level ? cfg.presence_wait_limit : cfg.presence_low_limit;
      PH_WAIT_HI:  len = cfg.presence_low_limit;
      PH_W_LOW:    len = {2'b00, sb[0] ? cfg.slot_short_ticks : cfg.slot_long_ticks};
      PH_W_REL:    len = {2'b00, sb[0] ? cfg.slot_long_ticks : cfg.slot_short_ticks};
      PH_R_LOW:    len = {2'b00, cfg.slot_short_ticks};
      PH_R_SAMP:   len = {2'b00, cfg.read_sample_ticks};
      PH_R_REC:    len = {2'b00, cfg.read_recovery_ticks};
      default:     len = '0;
    endcase
    // first low tick of the presence watch restarts the count
    tc_base = (ph == PH_WAIT_LOW && !line_level) ? '0 : tc;
    tc_inc  = tc_base + 1'b1;
    over    = tc_inc >= len;
  end

  always_comb begin
    nxt            = cur;
    nxt.bit_index  = bi;
    nxt.shift_byte = sb;
    nxt.tick_count = over ? '0 : tc_inc;
    nxt.phase      = ph;
    drive          = 1'b0;
    done           = 1'b0;
    unique case (ph)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (over) nxt.phase = PH_RST_REL;
      end
      PH_RST_REL: begin
        if (over) nxt.phase = PH_WAIT_LOW;
      end
      PH_WAIT_LOW: begin
        if (!line_level) nxt.phase = PH_WAIT_HI;
        if (over) begin
          nxt.presence_flag = 1'b0;
          nxt.phase         = PH_IDLE;
          done              = 1'b1;
        end
      end
      PH_WAIT_HI: begin
        if (line_level) begin
          nxt.tick_count    = '0;
          nxt.presence_flag = 1'b1;
          nxt.phase         = PH_IDLE;
          done              = 1'b1;
        end else if (over) begin
          nxt.presence_flag = 1'b0;
          nxt.phase         = PH_IDLE;
          done              = 1'b1;
        end
      end
      PH_W_LOW: begin
        drive = 1'b1;
        if (over) nxt.phase = PH_W_REL;
      end
      PH_W_REL: begin
        if (over) begin
          nxt.shift_byte = {1'b0, sb[7:1]};
          if (bi == 3'd7) begin
            nxt.bit_index = '0;
            nxt.phase     = PH_IDLE;
            done          = 1'b1;
          end else begin
            nxt.bit_index = bi + 1'b1;
            nxt.phase     = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: begin
        drive = 1'b1;
        if (over) nxt.phase = PH_R_SAMP;
      end
      PH_R_SAMP: begin
        if (over) begin
          nxt.shift_byte = {line_level, sb[7:1]};
          nxt.phase      = PH_R_REC;
        end
      end
      PH_R_REC: begin
        if (over) begin
          if (bi == 3'd7) begin
            nxt.bit_index = '0;
            nxt.last_read = sb;
            nxt.phase     = PH_IDLE;
            done          = 1'b1;
          end else begin
            nxt.bit_index = bi + 1'b1;
            nxt.phase     = PH_R_LOW;
          end
        end
      end
      default: begin
        // idle or unused code: count holds
        nxt.tick_count = tc;
        nxt.phase      = PH_IDLE;
      end
    endcase
  end

  assign res.drive_low      = drive;
  assign res.busy_res       = (nxt.phase != PH_IDLE);
  assign res.done_res       = done;
  assign res.read_value     = nxt.last_read;
  assign res.device_present = nxt.presence_flag;

endmodule

// ----- rtl/owbm_checker.sv -----
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic res_valid,
  input logic res_ready,
  input logic drive_low,
  input logic busy_res,
  input logic done_res
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> res_valid)
    else $error("accepted tick produced no result");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !tick_ready)
    else $error("tick taken while result stalled");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done and busy together");

  a_drive_when_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && drive_low |-> busy_res)
    else $error("bus driven low while idle");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(drive_low) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick.valid),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .drive_low  (result.drive_low),
  .busy_res   (result.busy_res),
  .done_res   (result.done_res)
);
